### hdl/bai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bai_pkg
// Shared widths, codes and defaults for the breakpoint automation interpolator.
// ----------------------------------------------------------------------------
package bai_pkg;

  localparam int VAL_W  = 32;  // Q16.16 point value
  localparam int TIME_W = 32;  // point time in samples
  localparam int BLK_W  = 24;  // saturating block counter
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam int DEF_MAX_POINTS    = 64;
  localparam int DEF_BLOCK_SAMPLES = 256;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TICK   = 2'd2
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

### hdl/breakpoint_automation_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_automation_interpolator_top
// Breakpoint table with step / linear interpolation, one value per audio block.
// ----------------------------------------------------------------------------
// Every transaction returns exactly one result. Clear, append, an opcode of 3,
// a tick on an empty table and a tick after the timeline has finished answer
// straight from the idle state. Any other tick walks the point table through a
// single read port, spending an S_SCAN and an S_CHECK state on each point it
// skips, then reads the two bracketing points; a step segment returns through
// S_PREV and S_DONE, and passing the last point through S_LAST and S_DONE. A
// linear segment goes on through a 32-step shift-add multiply and then a
// 64-step restoring divide, one bit per cycle, and S_RES. The input is held off
// while a tick is in progress and while a result waits to be taken.
module breakpoint_automation_interpolator_top #(
  parameter int MAX_POINTS    = bai_pkg::DEF_MAX_POINTS,
  parameter int BLOCK_SAMPLES = bai_pkg::DEF_BLOCK_SAMPLES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bai_pkg::OP_W-1:0]          opcode_i,
  input  logic [bai_pkg::TIME_W-1:0]        point_time_i,
  input  logic                              point_linear_i,
  input  logic signed [bai_pkg::VAL_W-1:0]  point_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bai_pkg::VAL_W-1:0]  value_o,
  output logic                              value_valid_o,
  output logic                              finished_o,
  output logic [bai_pkg::ST_W-1:0]          status_o
);

  localparam int VAL_W  = bai_pkg::VAL_W;
  localparam int TIME_W = bai_pkg::TIME_W;
  localparam int BLK_W  = bai_pkg::BLK_W;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int T_W    = BLK_W + $clog2(BLOCK_SAMPLES + 1);
  localparam int CMP_W  = (T_W > TIME_W) ? T_W : TIME_W;
  localparam int PROD_W = 2 * VAL_W;
  localparam int STEP_W = $clog2(PROD_W);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHECK, S_LAST, S_PREV, S_MUL, S_DIV, S_RES, S_DONE
  } state_e;

  state_e state_q;

  // point table
  logic [TIME_W-1:0] times_mem  [MAX_POINTS];
  logic [VAL_W-1:0]  values_mem [MAX_POINTS];
  logic              modes_mem  [MAX_POINTS];
  logic [TIME_W-1:0] rd_time_q;
  logic [VAL_W-1:0]  rd_value_q;
  logic              rd_mode_q;
  logic [IDX_W-1:0]  rd_addr;

  logic [CNT_W-1:0]  count_q, next_idx_q;
  logic [TIME_W-1:0] last_time_q;
  logic [BLK_W-1:0]  block_count_q;
  logic              done_q;
  logic [CMP_W-1:0]  t_q;

  // segment operands
  logic [TIME_W-1:0] t2_q, den_q;
  logic [VAL_W-1:0]  v1_q, v2_q;
  logic              lin_q, neg_q;

  // shared multiply / divide datapath
  logic [PROD_W-1:0] acc_q, mcand_q;
  logic [VAL_W-1:0]  mplier_q;
  logic [VAL_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;

  logic [VAL_W-1:0]  res_value_q;
  logic              res_valid_q, res_fin_q;

  logic signed [VAL_W-1:0] out_value_q;
  logic                    out_valid_q, out_vv_q, out_fin_q;
  logic [bai_pkg::ST_W-1:0] out_status_q;

  logic             in_fire, out_free, full, order_bad, wr_en, scan_end;
  logic             tick_run, out_load;
  logic [CNT_W-1:0] cnt_m1, idx_m1;
  logic [VAL_W:0]   diff;
  logic [VAL_W-1:0] mag;
  logic [CMP_W-1:0] num_full;
  logic [VAL_W:0]   rem_sh;
  logic             rem_ge;
  logic [VAL_W-1:0] quot;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full      = count_q >= CNT_W'(MAX_POINTS);
  assign order_bad = (count_q != '0) && (point_time_i < last_time_q);
  assign wr_en     = in_fire && (opcode_i == bai_pkg::OP_APPEND) && !full && !order_bad;
  assign scan_end  = next_idx_q >= count_q;
  assign cnt_m1    = count_q - CNT_W'(1);
  assign idx_m1    = next_idx_q - CNT_W'(1);

  // a tick that has to walk the table answers later from S_DONE
  assign tick_run = (opcode_i == bai_pkg::OP_TICK) && (count_q != '0) && !done_q;
  assign out_load = (state_q == S_IDLE) ? (in_fire && !tick_run)
                                        : ((state_q == S_DONE) && out_free);

  always_comb begin
    rd_addr = next_idx_q[IDX_W-1:0];
    case (state_q)
      S_SCAN:  rd_addr = scan_end ? cnt_m1[IDX_W-1:0] : next_idx_q[IDX_W-1:0];
      // fetch the earlier point of the segment while the later one is checked
      S_CHECK: rd_addr = (next_idx_q == '0) ? next_idx_q[IDX_W-1:0] : idx_m1[IDX_W-1:0];
      default: rd_addr = next_idx_q[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      times_mem[count_q[IDX_W-1:0]]  <= point_time_i;
      values_mem[count_q[IDX_W-1:0]] <= point_value_i;
      modes_mem[count_q[IDX_W-1:0]]  <= point_linear_i;
    end
    rd_time_q  <= times_mem[rd_addr];
    rd_value_q <= values_mem[rd_addr];
    rd_mode_q  <= modes_mem[rd_addr];
  end

  // segment setup: v2 - v1 as sign and magnitude, t - t1 fits 32 bits since t < t2
  assign diff     = {v2_q[VAL_W-1], v2_q} - {rd_value_q[VAL_W-1], rd_value_q};
  assign mag      = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
  assign num_full = t_q - CMP_W'(rd_time_q);

  // restoring divide step
  assign rem_sh = {rem_q, acc_q[PROD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign quot   = acc_q[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      next_idx_q    <= '0;
      last_time_q   <= '0;
      block_count_q <= '0;
      done_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      step_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            out_value_q <= '0;
            out_vv_q    <= 1'b0;
            out_fin_q   <= (opcode_i == bai_pkg::OP_CLEAR) ? 1'b0 : done_q;
            case (opcode_i)
              bai_pkg::OP_CLEAR: begin
                out_status_q  <= bai_pkg::ST_OK;
                count_q       <= '0;
                next_idx_q    <= '0;
                block_count_q <= '0;
                done_q        <= 1'b0;
              end
              bai_pkg::OP_APPEND: begin
                if (full) begin
                  out_status_q <= bai_pkg::ST_FULL;
                end else if (order_bad) begin
                  out_status_q <= bai_pkg::ST_ORDER;
                end else begin
                  out_status_q <= bai_pkg::ST_OK;
                  count_q      <= count_q + CNT_W'(1);
                  last_time_q  <= point_time_i;
                end
              end
              bai_pkg::OP_TICK: begin
                if (count_q == '0) begin
                  out_status_q <= bai_pkg::ST_EMPTY;
                end else begin
                  out_status_q <= bai_pkg::ST_OK;
                  t_q <= CMP_W'(block_count_q) * CMP_W'(BLOCK_SAMPLES);
                  if (block_count_q != '1) begin
                    block_count_q <= block_count_q + BLK_W'(1);
                  end
                  if (!done_q) begin
                    state_q <= S_SCAN;
                  end
                end
              end
              default: out_status_q <= bai_pkg::ST_OK;
            endcase
          end
        end
        S_SCAN: begin
          state_q <= scan_end ? S_LAST : S_CHECK;
        end
        S_LAST: begin
          res_value_q <= rd_value_q;
          res_valid_q <= 1'b1;
          res_fin_q   <= 1'b1;
          done_q      <= 1'b1;
          state_q     <= S_DONE;
        end
        S_CHECK: begin
          if (CMP_W'(rd_time_q) <= t_q) begin
            next_idx_q <= next_idx_q + CNT_W'(1);
            state_q    <= S_SCAN;
          end else if (next_idx_q == '0) begin
            // timeline is still before the first point
            res_value_q <= '0;
            res_valid_q <= 1'b0;
            res_fin_q   <= 1'b0;
            state_q     <= S_DONE;
          end else begin
            t2_q    <= rd_time_q;
            v2_q    <= rd_value_q;
            lin_q   <= rd_mode_q;
            state_q <= S_PREV;
          end
        end
        S_PREV: begin
          res_valid_q <= 1'b1;
          res_fin_q   <= 1'b0;
          if (!lin_q) begin
            res_value_q <= rd_value_q;
            state_q     <= S_DONE;
          end else begin
            v1_q     <= rd_value_q;
            neg_q    <= diff[VAL_W];
            mcand_q  <= PROD_W'(mag);
            mplier_q <= num_full[VAL_W-1:0];
            den_q    <= t2_q - rd_time_q;
            acc_q    <= '0;
            step_q   <= '0;
            state_q  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[VAL_W-1:1]};
          if (step_q == STEP_W'(VAL_W - 1)) begin
            step_q  <= '0;
            rem_q   <= '0;
            state_q <= S_DIV;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_DIV: begin
          // quotient bits shift into acc as the dividend shifts out
          rem_q  <= rem_ge ? VAL_W'(rem_sh - {1'b0, den_q}) : rem_sh[VAL_W-1:0];
          acc_q  <= {acc_q[PROD_W-2:0], rem_ge};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(PROD_W - 1)) begin
            state_q <= S_RES;
          end
        end
        S_RES: begin
          res_value_q <= neg_q ? (v1_q - quot) : (v1_q + quot);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_value_q  <= res_value_q;
            out_vv_q     <= res_valid_q;
            out_fin_q    <= res_fin_q;
            out_status_q <= bai_pkg::ST_OK;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign value_valid_o = out_vv_q;
  assign finished_o    = out_fin_q;
  assign status_o      = out_status_q;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_idx_q <= count_q)
    else $error("scan index beyond point count");

  a_no_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !value_valid_o |-> value_o == '0)
    else $error("value not zero without value_valid");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && opcode_i == bai_pkg::OP_CLEAR |=>
      out_valid_o && !finished_o && !value_valid_o && count_q == '0)
    else $error("clear did not restart timeline");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE && (!out_valid_o || out_ready_i))
    else $error("input ready while busy or result blocked");

endmodule
